// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TSG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TSG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tsg_pkg.sv =====
// ----------------------------------------------------------------------------
// tsg_pkg
// Widths, register indexes, reset values and the sine table of the tone
// generator.
// ----------------------------------------------------------------------------
package tsg_pkg;

  localparam int VolumeW     = 16;
  localparam int WarpW       = 16;
  localparam int FrameCountW = 7;
  localparam int SampleW     = 17;
  localparam int BaseStepW   = 24;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 24;

  localparam int WarpFracBits = 12;
  localparam int VolFracBits  = 15;

  // The sine table has a fixed length of 256 entries.
  localparam int TableLength = 256;
  localparam int TableBits   = 8;
  localparam int EntryW      = 16;

  localparam logic [CfgIdxW-1:0] CfgVolumeFloor   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgVolumeCeiling = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgWarpFloor     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgWarpCeiling   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgBaseStep      = 3'd4;

  localparam logic [VolumeW-1:0]   VolumeFloorRst   = 16'd0;
  localparam logic [VolumeW-1:0]   VolumeCeilingRst = 16'd32768;
  localparam logic [WarpW-1:0]     WarpFloorRst     = 16'd2048;
  localparam logic [WarpW-1:0]     WarpCeilingRst   = 16'd8192;
  localparam logic [BaseStepW-1:0] BaseStepRst      = 24'd153791;

  localparam longint unsigned TrigOne = 64'd1 << 28;
  localparam longint unsigned PiTrig  = 64'd843314857;

  typedef logic [EntryW-1:0] sine_rom_t [TableLength];

  // sin(pi*u/TableLength) in Q1.15 for u up to half the table, by a
  // nested Taylor series in Q4.28.
  function automatic logic [EntryW-1:0] quarter_sine(longint unsigned u);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    x  = (PiTrig * u + 64'd128) >> TableBits;
    x2 = (x * x) >> 28;
    t  = TrigOne;
    t  = TrigOne - ((x2 * t) >> 28) / 210;
    t  = TrigOne - ((x2 * t) >> 28) / 156;
    t  = TrigOne - ((x2 * t) >> 28) / 110;
    t  = TrigOne - ((x2 * t) >> 28) / 72;
    t  = TrigOne - ((x2 * t) >> 28) / 42;
    t  = TrigOne - ((x2 * t) >> 28) / 20;
    t  = TrigOne - ((x2 * t) >> 28) / 6;
    s  = (x * t) >> 28;
    s  = (s + 64'd4096) >> 13;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return s[EntryW-1:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t       rom;
    longint unsigned u;
    logic            neg;
    logic [EntryW-1:0] m;
    for (int i = 0; i < TableLength; i++) begin
      u   = 64'(2 * i);
      neg = 1'b0;
      if (u >= 64'(TableLength)) begin
        u   = u - 64'(TableLength);
        neg = 1'b1;
      end
      if (2 * u > 64'(TableLength)) begin
        u = 64'(TableLength) - u;
      end
      m      = quarter_sine(u);
      rom[i] = neg ? (16'd0 - m) : m;
    end
    return rom;
  endfunction

  localparam sine_rom_t SineRom = build_sine_rom();

endpackage

// ===== rtl/tsg_in_if.sv =====
// ----------------------------------------------------------------------------
// tsg_in_if
// Request channel: volume, warp factor and frame count with valid and ready.
// ----------------------------------------------------------------------------
interface tsg_in_if;
  logic                             valid;
  logic                             ready;
  logic [tsg_pkg::VolumeW-1:0]      volume;
  logic [tsg_pkg::WarpW-1:0]        warp;
  logic [tsg_pkg::FrameCountW-1:0]  frame_count;

  modport source (output valid, volume, warp, frame_count, input ready);
  modport sink   (input valid, volume, warp, frame_count, output ready);
endinterface

// ===== rtl/tsg_out_if.sv =====
// ----------------------------------------------------------------------------
// tsg_out_if
// Sample channel: signed sample and last marker with valid and ready.
// ----------------------------------------------------------------------------
interface tsg_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [tsg_pkg::SampleW-1:0] sample;
  logic                               last_frame;

  modport source (output valid, sample, last_frame, input ready);
  modport sink   (input valid, sample, last_frame, output ready);
endinterface

// ===== rtl/table_sine_tone_generator.sv =====
// ----------------------------------------------------------------------------
// table_sine_tone_generator
// Table-driven sine oscillator: one request gives a burst of scaled samples.
// ----------------------------------------------------------------------------
// Each request is taken only while the generator is idle. After the transfer
// the S_STEP state computes the phase step on the shared 24x17 multiplier,
// and then every frame passes through S_ADV, which advances the phase and
// reads the sine table, and S_MUL, which scales the entry by the volume on
// the same multiplier. The input stays closed until the last sample of the
// burst has been computed; a stalled sink holds the sequencer in S_MUL, its
// scaling state. The last sample may still wait in the output register
// while the next request is taken.
module table_sine_tone_generator #(
  parameter int MAX_BURST       = 64,
  parameter int PHASE_FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tsg_in_if.sink                        in_if,
  tsg_out_if.source                     out_if,
  input  logic                          cfg_we_i,
  input  logic [tsg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tsg_pkg::CfgDataW-1:0]  cfg_data_i
);

  `include "assert_macros.svh"

  localparam int PhaseW = tsg_pkg::TableBits + PHASE_FRAC_BITS;
  localparam int StepW  = (PhaseW > 28) ? PhaseW : 28;
  localparam int MulAW  = tsg_pkg::BaseStepW;
  localparam int MulBW  = tsg_pkg::SampleW;
  localparam int ProdW  = MulAW + MulBW;
  localparam int FcW    = tsg_pkg::FrameCountW;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_STEP = 4'b0010,
    S_ADV  = 4'b0100,
    S_MUL  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [tsg_pkg::VolumeW-1:0]   vol_floor_q, vol_ceil_q;
  logic [tsg_pkg::WarpW-1:0]     warp_floor_q, warp_ceil_q;
  logic [tsg_pkg::BaseStepW-1:0] base_step_q;

  logic [PhaseW-1:0]             phase_q, phase_d;
  logic [PhaseW-1:0]             step_q, step_d;
  logic [FcW-1:0]                frames_left_q, frames_left_d;
  logic [tsg_pkg::VolumeW-1:0]   vol_q, vol_d;
  logic [tsg_pkg::WarpW-1:0]     warp_q, warp_d;
  logic [tsg_pkg::EntryW-1:0]    entry_q, entry_d;
  logic                          out_valid_q, out_valid_d;
  logic [tsg_pkg::SampleW-1:0]   out_sample_q, out_sample_d;
  logic                          out_last_q, out_last_d;

  logic in_fire, out_fire, out_free;

  logic [tsg_pkg::VolumeW-1:0] vol_raised, vol_clamped;
  logic [tsg_pkg::WarpW-1:0]   warp_raised, warp_clamped;
  logic [FcW-1:0]              frames_sat;

  logic [MulAW-1:0]            mul_a;
  logic [MulBW-1:0]            mul_b;
  logic [ProdW-1:0]            prod;
  logic [StepW-1:0]            step_ext;
  logic                        entry_neg;
  logic [MulBW-1:0]            mag;
  logic [ProdW-1:0]            rounded;
  logic [tsg_pkg::SampleW-1:0] sample_mag;

  assign in_if.ready = (state_q == S_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign out_fire    = out_valid_q && out_if.ready;
  assign out_free    = !out_valid_q || out_if.ready;

  assign out_if.valid      = out_valid_q;
  assign out_if.sample     = out_sample_q;
  assign out_if.last_frame = out_last_q;

  // Raise to the floor first, then lower to the ceiling: the ceiling wins.
  assign vol_raised   = (in_if.volume < vol_floor_q) ? vol_floor_q : in_if.volume;
  assign vol_clamped  = (vol_raised > vol_ceil_q) ? vol_ceil_q : vol_raised;
  assign warp_raised  = (in_if.warp < warp_floor_q) ? warp_floor_q : in_if.warp;
  assign warp_clamped = (warp_raised > warp_ceil_q) ? warp_ceil_q : warp_raised;
  assign frames_sat   = (in_if.frame_count > FcW'(MAX_BURST)) ? FcW'(MAX_BURST)
                                                               : in_if.frame_count;

  // Shared multiplier: base step times warp, or volume times table magnitude.
  assign entry_neg = entry_q[tsg_pkg::EntryW-1];
  assign mag       = entry_neg ? (MulBW'(17'h10000) - MulBW'(entry_q)) : MulBW'(entry_q);
  assign mul_a     = (state_q == S_STEP) ? base_step_q : MulAW'(vol_q);
  assign mul_b     = (state_q == S_STEP) ? MulBW'(warp_q) : mag;
  assign prod      = ProdW'(mul_a) * ProdW'(mul_b);

  assign step_ext   = StepW'(prod >> tsg_pkg::WarpFracBits);
  assign rounded    = (prod + (ProdW'(1) << (tsg_pkg::VolFracBits - 1)))
                      >> tsg_pkg::VolFracBits;
  assign sample_mag = rounded[tsg_pkg::SampleW-1:0];

  always_comb begin
    state_d       = state_q;
    phase_d       = phase_q;
    step_d        = step_q;
    frames_left_d = frames_left_q;
    vol_d         = vol_q;
    warp_d        = warp_q;
    entry_d       = entry_q;
    out_valid_d   = out_fire ? 1'b0 : out_valid_q;
    out_sample_d  = out_sample_q;
    out_last_d    = out_last_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          vol_d         = vol_clamped;
          warp_d        = warp_clamped;
          frames_left_d = frames_sat;
          if (frames_sat != '0) begin
            state_d = S_STEP;
          end
        end
      end
      S_STEP: begin
        step_d  = step_ext[PhaseW-1:0];
        state_d = S_ADV;
      end
      S_ADV: begin
        // The phase wraps modulo the table length by plain truncation.
        phase_d = phase_q + step_q;
        entry_d = tsg_pkg::SineRom[phase_d[PhaseW-1 -: tsg_pkg::TableBits]];
        state_d = S_MUL;
      end
      S_MUL: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_sample_d  = entry_neg ? (tsg_pkg::SampleW'(0) - sample_mag) : sample_mag;
          out_last_d    = (frames_left_q == FcW'(1));
          frames_left_d = frames_left_q - FcW'(1);
          state_d       = (frames_left_q == FcW'(1)) ? S_IDLE : S_ADV;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      phase_q       <= '0;
      frames_left_q <= '0;
      out_valid_q   <= 1'b0;
      vol_floor_q   <= tsg_pkg::VolumeFloorRst;
      vol_ceil_q    <= tsg_pkg::VolumeCeilingRst;
      warp_floor_q  <= tsg_pkg::WarpFloorRst;
      warp_ceil_q   <= tsg_pkg::WarpCeilingRst;
      base_step_q   <= tsg_pkg::BaseStepRst;
    end else begin
      state_q       <= state_d;
      phase_q       <= phase_d;
      frames_left_q <= frames_left_d;
      out_valid_q   <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tsg_pkg::CfgVolumeFloor:   vol_floor_q  <= cfg_data_i[tsg_pkg::VolumeW-1:0];
          tsg_pkg::CfgVolumeCeiling: vol_ceil_q   <= cfg_data_i[tsg_pkg::VolumeW-1:0];
          tsg_pkg::CfgWarpFloor:     warp_floor_q <= cfg_data_i[tsg_pkg::WarpW-1:0];
          tsg_pkg::CfgWarpCeiling:   warp_ceil_q  <= cfg_data_i[tsg_pkg::WarpW-1:0];
          tsg_pkg::CfgBaseStep:      base_step_q  <= cfg_data_i[tsg_pkg::BaseStepW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    step_q       <= step_d;
    vol_q        <= vol_d;
    warp_q       <= warp_d;
    entry_q      <= entry_d;
    out_sample_q <= out_sample_d;
    out_last_q   <= out_last_d;
  end

  // A request is only taken once the previous burst has been fully computed.
  `TSG_ASSERT_SAME(a_idle_no_frames, in_if.ready, frames_left_q == '0, "ready with frames pending")

  // A sample that is not the last one leaves frames still to compute.
  `TSG_ASSERT_SAME(a_mid_burst, out_valid_q && !out_last_q, frames_left_q != '0, "burst count lost")

  // A non-empty request goes straight to the step computation.
  `TSG_ASSERT_NEXT(a_req_start, in_fire && (in_if.frame_count != '0), state_q == S_STEP, "request not started")

endmodule
